### rtl/iit_pkg.sv
// Shared types, widths and constants of the identity intern table.
package iit_pkg;

    localparam int PARENT_W = 11;
    localparam int NAME_W   = 32;
    localparam int KIND_W   = 8;
    localparam int STATUS_W = 2;
    localparam int OUT_W    = 11;
    localparam int HASH_W   = 32;

    localparam int DEF_CAPACITY = 1024;
    localparam int DEF_BUCKETS  = 2048;

    localparam logic [HASH_W-1:0] GOLDEN = 32'h9e37_79b9;

    localparam logic [STATUS_W-1:0] ST_OK            = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID       = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_AVAILABLE = 2'd2;

    typedef struct packed {
        logic [PARENT_W-1:0] parent;
        logic [NAME_W-1:0]   name;
        logic [KIND_W-1:0]   kind;
    } t_key;

    localparam int KEY_W = $bits(t_key);

endpackage

### rtl/identity_intern_table_unit.sv
// Top level of the identity intern table: sequencer, probe loop and result register.
//
// A request transaction on the input channel (i_valid / o_ready) carries a parent flag,
// a parent slot, a name id and a kind; exactly one result transaction on the output
// channel (o_valid / i_ready) answers it with a status, a slot id and the registry size
// after the request. Requests are handled one at a time: o_ready is high only while
// the sequencer is idle.
//
// An invalid request (null parent, zero name, zero kind, unassigned parent) goes from
// acceptance straight to the result state, which loads the output register once it is
// free. A valid request passes both rounds of the shared mixing unit, the state that
// issues the first bucket read, one compare per probe of the bucket memory (at most
// BUCKETS probes, one on a lightly loaded table) and the result state. A bucket count
// that is not a power of two adds a reciprocal reduction after mixing. The next
// request can be accepted in the cycle after the result is loaded.
//
// After reset the block sweeps all BUCKETS words of the bucket memory, clearing every
// valid bit, with o_ready low; the entry count returns to zero. If the receiver holds
// i_ready low, the next request is still taken in, but its result waits in the
// sequencer, with o_ready low, until the output register is free.
module identity_intern_table_unit
    import iit_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    parameter int BUCKETS  = DEF_BUCKETS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Request channel.
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_parent_present,
    input  logic [PARENT_W-1:0] i_parent_slot,
    input  logic [NAME_W-1:0]   i_name_id,
    input  logic [KIND_W-1:0]   i_kind_code,
    // Result channel.
    output logic                o_valid,
    input  logic                i_ready,
    output logic [STATUS_W-1:0] o_result_status,
    output logic [OUT_W-1:0]    o_slot_id,
    output logic [OUT_W-1:0]    o_registry_size
);

    // Slot ids run from 1 to CAPACITY; slot 0 is the root.
    localparam int SLOT_W  = $clog2(CAPACITY + 1);
    localparam int IDX_W   = $clog2(BUCKETS);
    localparam int EXT_W   = (SLOT_W > PARENT_W) ? SLOT_W : PARENT_W;
    localparam int WORD_W  = 1 + KEY_W + SLOT_W;
    localparam bit IS_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);
    // Reciprocal of the bucket count scaled by 2^32 and rounded down, so the
    // quotient estimate taken from it is exact or one too small.
    localparam logic [HASH_W-1:0] RECIP = HASH_W'((64'd1 << HASH_W) / 64'(BUCKETS));

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_H1    = 3'd2;
    localparam logic [2:0] S_H2    = 3'd3;
    localparam logic [2:0] S_MOD   = 3'd4;
    localparam logic [2:0] S_RD    = 3'd5;
    localparam logic [2:0] S_CMP   = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0]          r_state, n_state;
    t_key                r_key, n_key;
    logic [HASH_W-1:0]   r_hash, n_hash;
    logic [HASH_W-1:0]   r_quot, n_quot;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [IDX_W:0]      r_probe, n_probe;
    logic [1:0]          r_step, n_step;
    logic [SLOT_W-1:0]   r_count, n_count;
    logic [STATUS_W-1:0] r_res_status, n_res_status;
    logic [SLOT_W-1:0]   r_res_slot, n_res_slot;
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [OUT_W-1:0]    r_out_slot;
    logic [OUT_W-1:0]    r_out_size;

    // Shared mixing unit.
    logic [HASH_W-1:0] mix_h, mix_v, mix_out;

    // Bucket memory ports.
    logic              wr_en, rd_en;
    logic [IDX_W-1:0]  wr_addr, rd_addr;
    logic [WORD_W-1:0] wr_data, rd_word;

    // Fields of the word read back from the bucket memory.
    logic              rd_valid;
    t_key              rd_key;
    logic [SLOT_W-1:0] rd_slot;

    logic                in_fire;
    logic                req_bad;
    logic [2*HASH_W-1:0] recip_prod;
    logic [HASH_W-1:0]   quot_prod;
    logic [IDX_W-1:0]    idx_next;
    logic                out_load;
    logic [EXT_W-1:0]    res_slot_ext;
    logic [EXT_W-1:0]    size_ext;

    assign o_ready = (r_state == S_IDLE);
    assign in_fire = i_valid && o_ready;

    assign req_bad = !i_parent_present || (i_name_id == '0) || (i_kind_code == '0) ||
                     (EXT_W'(i_parent_slot) > EXT_W'(r_count));

    assign rd_valid = rd_word[WORD_W-1];
    assign rd_key   = rd_word[WORD_W-2 -: KEY_W];
    assign rd_slot  = rd_word[SLOT_W-1:0];

    // Reduction of the hash by a bucket count that is not a power of two.
    assign recip_prod = (2*HASH_W)'(r_hash) * (2*HASH_W)'(RECIP);
    assign quot_prod  = r_quot * HASH_W'(BUCKETS);

    assign idx_next = (r_idx == IDX_W'(BUCKETS - 1)) ? '0 : r_idx + 1'b1;

    assign mix_h = (r_state == S_H1) ? HASH_W'(r_key.parent) : r_hash;
    assign mix_v = (r_state == S_H1) ? r_key.name : HASH_W'(r_key.kind);

    iit_mix u_mix (
        .i_h (mix_h),
        .i_v (mix_v),
        .o_h (mix_out)
    );

    iit_bucket_ram #(
        .DEPTH  (BUCKETS),
        .DATA_W (WORD_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_word)
    );

    always_comb begin
        n_state      = r_state;
        n_key        = r_key;
        n_hash       = r_hash;
        n_quot       = r_quot;
        n_idx        = r_idx;
        n_probe      = r_probe;
        n_step       = r_step;
        n_count      = r_count;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        wr_en        = 1'b0;
        wr_addr      = r_idx;
        wr_data      = '0;
        rd_en        = 1'b0;
        rd_addr      = r_idx;
        out_load     = 1'b0;

        case (r_state)
            S_CLEAR: begin
                wr_en = 1'b1;
                n_idx = r_idx + 1'b1;
                if (r_idx == IDX_W'(BUCKETS - 1)) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_fire) begin
                    n_key.parent = i_parent_slot;
                    n_key.name   = i_name_id;
                    n_key.kind   = i_kind_code;
                    if (req_bad) begin
                        n_res_status = ST_INVALID;
                        n_res_slot   = '0;
                        n_state      = S_OUT;
                    end else begin
                        n_state = S_H1;
                    end
                end
            end
            S_H1: begin
                n_hash  = mix_out;
                n_state = S_H2;
            end
            S_H2: begin
                n_hash = mix_out;
                if (IS_POW2) begin
                    n_idx   = mix_out[IDX_W-1:0];
                    n_state = S_RD;
                end else begin
                    n_step  = 2'd2;
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                // Quotient estimate, then the remainder below twice the bucket
                // count, then one conditional subtraction.
                n_step = r_step - 1'b1;
                if (r_step == 2'd2) begin
                    n_quot = recip_prod[2*HASH_W-1:HASH_W];
                end else if (r_step == 2'd1) begin
                    n_hash = r_hash - quot_prod;
                end else begin
                    n_idx   = (r_hash >= HASH_W'(BUCKETS)) ?
                              IDX_W'(r_hash - HASH_W'(BUCKETS)) : r_hash[IDX_W-1:0];
                    n_state = S_RD;
                end
            end
            S_RD: begin
                rd_en   = 1'b1;
                n_probe = (IDX_W+1)'(1);
                n_state = S_CMP;
            end
            S_CMP: begin
                if (!rd_valid) begin
                    // Empty bucket: the triple is new.
                    if (r_count >= SLOT_W'(CAPACITY)) begin
                        n_res_status = ST_NOT_AVAILABLE;
                        n_res_slot   = '0;
                    end else begin
                        n_count      = r_count + 1'b1;
                        wr_en        = 1'b1;
                        wr_data      = {1'b1, r_key, n_count};
                        n_res_status = ST_OK;
                        n_res_slot   = n_count;
                    end
                    n_state = S_OUT;
                end else if (rd_key == r_key) begin
                    n_res_status = ST_OK;
                    n_res_slot   = rd_slot;
                    n_state      = S_OUT;
                end else if (r_probe == (IDX_W+1)'(BUCKETS)) begin
                    n_res_status = ST_NOT_AVAILABLE;
                    n_res_slot   = '0;
                    n_state      = S_OUT;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = idx_next;
                    n_idx   = idx_next;
                    n_probe = r_probe + 1'b1;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign res_slot_ext = EXT_W'(r_res_slot);
    assign size_ext     = EXT_W'(r_count) + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_count <= n_count;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key        <= n_key;
        r_hash       <= n_hash;
        r_quot       <= n_quot;
        r_probe      <= n_probe;
        r_step       <= n_step;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        if (out_load) begin
            r_out_status <= r_res_status;
            r_out_slot   <= res_slot_ext[OUT_W-1:0];
            r_out_size   <= size_ext[OUT_W-1:0];
        end
    end

    assign o_valid         = r_out_valid;
    assign o_result_status = r_out_status;
    assign o_slot_id       = r_out_slot;
    assign o_registry_size = r_out_size;

endmodule

### rtl/iit_mix.sv
// One round of the golden-ratio shift mixing hash, shared by both rounds.
module iit_mix
    import iit_pkg::*;
(
    input  logic [HASH_W-1:0] i_h,
    input  logic [HASH_W-1:0] i_v,
    output logic [HASH_W-1:0] o_h
);

    assign o_h = i_h ^ (i_v + GOLDEN + {i_h[HASH_W-7:0], 6'b0} + {2'b0, i_h[HASH_W-1:2]});

endmodule

### rtl/iit_bucket_ram.sv
// Bucket memory with one write port and one registered read port.
module iit_bucket_ram
    import iit_pkg::*;
#(
    parameter int DEPTH  = DEF_BUCKETS,
    parameter int DATA_W = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DATA_W-1:0]        i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [DATA_W-1:0]        o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### dv/tb_top.sv
// Self-checking testbench of the identity intern table unit.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import iit_pkg::*;

    // The run is cut off here if the block stops making progress.
    localparam int CYCLE_LIMIT   = 1_000_000;
    // After the last result, this many cycles are watched for stray transactions.
    localparam int DRAIN_CYCLES  = 64;
    localparam int REPORT_LIMIT  = 10;
    localparam int RANDOM_ITEMS  = 1750;

    // One result transaction, in port order.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OUT_W-1:0]    slot;
        logic [OUT_W-1:0]    size;
    } t_intern_result;

    // Malformed request flavors used as noise in the random traffic.
    typedef enum int {
        NOISE_NULL_PARENT,
        NOISE_ZERO_NAME,
        NOISE_ZERO_KIND,
        NOISE_UNKNOWN_PARENT
    } t_noise_kind;

    // Every input of the block holds a known value from time zero.
    logic                i_clk            = 1'b0;
    logic                i_rst_n          = 1'b0;
    logic                i_valid          = 1'b0;
    logic                i_parent_present = 1'b0;
    logic [PARENT_W-1:0] i_parent_slot    = '0;
    logic [NAME_W-1:0]   i_name_id        = '0;
    logic [KIND_W-1:0]   i_kind_code      = '0;
    logic                i_ready          = 1'b0;
    logic                o_ready;
    logic                o_valid;
    logic [STATUS_W-1:0] o_result_status;
    logic [OUT_W-1:0]    o_slot_id;
    logic [OUT_W-1:0]    o_registry_size;

    identity_intern_table_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_parent_present (i_parent_present),
        .i_parent_slot    (i_parent_slot),
        .i_name_id        (i_name_id),
        .i_kind_code      (i_kind_code),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_result_status  (o_result_status),
        .o_slot_id        (o_slot_id),
        .o_registry_size  (o_registry_size)
    );

    // Free-running 2 ns clock.
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Shadow copy of the intern table. The bucket store mirrors the probed hash
    // store; the slot table maps each assigned slot back to its triple so that
    // the stimulus can ask for identities that already exist.
    // ------------------------------------------------------------------------
    bit                  bkt_valid  [DEF_BUCKETS];
    logic [PARENT_W-1:0] bkt_parent [DEF_BUCKETS];
    logic [NAME_W-1:0]   bkt_name   [DEF_BUCKETS];
    logic [KIND_W-1:0]   bkt_kind   [DEF_BUCKETS];
    logic [OUT_W-1:0]    bkt_slot   [DEF_BUCKETS];
    logic [PARENT_W-1:0] slot_parent [DEF_CAPACITY+1];
    logic [NAME_W-1:0]   slot_name   [DEF_CAPACITY+1];
    logic [KIND_W-1:0]   slot_kind   [DEF_CAPACITY+1];
    int unsigned         stored_count = 0;

    // Results predicted at request acceptance, oldest first.
    t_intern_result      expected_results [$];
    int                  mismatch_count = 0;
    int                  cycle_count    = 0;

    // Idle rates in percent; the test tasks change them between phases.
    int                  send_idle_pct = 14;
    int                  recv_idle_pct = 83;

    // Looks a triple up in the shadow table, inserting it when it is new, and
    // returns the result the block must give for this request.
    function automatic t_intern_result intern_lookup(
        input logic                present,
        input logic [PARENT_W-1:0] parent,
        input logic [NAME_W-1:0]   name,
        input logic [KIND_W-1:0]   kind
    );
        t_intern_result   r;
        logic [HASH_W-1:0] h;
        int unsigned      idx;
        int unsigned      free_idx;
        int               probe;
        bit               stop;
        bit               hit;
        bit               free_found;
        r          = '0;
        free_idx   = 0;
        probe      = 0;
        stop       = 1'b0;
        hit        = 1'b0;
        free_found = 1'b0;
        if (!present || name == '0 || kind == '0 || parent > stored_count) begin
            r.status = ST_INVALID;
        end else begin
            // Golden-ratio shift mixing, all arithmetic modulo 2^32.
            h   = HASH_W'(parent);
            h   = h ^ (HASH_W'(name) + GOLDEN + (h << 6) + (h >> 2));
            h   = h ^ (HASH_W'(kind) + GOLDEN + (h << 6) + (h >> 2));
            idx = h % DEF_BUCKETS;
            // Linear probe: stop at an empty bucket or at the matching triple.
            while (!stop && probe < DEF_BUCKETS) begin
                if (!bkt_valid[idx]) begin
                    free_found = 1'b1;
                    free_idx   = idx;
                    stop       = 1'b1;
                end else if (bkt_parent[idx] == parent && bkt_name[idx] == name &&
                             bkt_kind[idx] == kind) begin
                    hit      = 1'b1;
                    r.status = ST_OK;
                    r.slot   = bkt_slot[idx];
                    stop     = 1'b1;
                end else begin
                    idx   = (idx + 1) % DEF_BUCKETS;
                    probe = probe + 1;
                end
            end
            if (!hit) begin
                if (stored_count >= DEF_CAPACITY || !free_found) begin
                    r.status = ST_NOT_AVAILABLE;
                end else begin
                    stored_count               = stored_count + 1;
                    bkt_valid[free_idx]        = 1'b1;
                    bkt_parent[free_idx]       = parent;
                    bkt_name[free_idx]         = name;
                    bkt_kind[free_idx]         = kind;
                    bkt_slot[free_idx]         = OUT_W'(stored_count);
                    slot_parent[stored_count]  = parent;
                    slot_name[stored_count]    = name;
                    slot_kind[stored_count]    = kind;
                    r.status                   = ST_OK;
                    r.slot                     = OUT_W'(stored_count);
                end
            end
        end
        r.size = OUT_W'(stored_count + 1);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Request side. Inputs change only at the falling edge. The sender may idle
    // at the current idle rate before each transaction; once valid is raised it stays
    // up with a steady payload until the rising edge that sees o_ready. The
    // expected result is computed at that edge, in acceptance order. Valid is
    // not dropped after acceptance: the next call either idles or presents the
    // next request, so each falling edge carries a single update of i_valid.
    // ------------------------------------------------------------------------
    task automatic send_request(
        input logic                present,
        input logic [PARENT_W-1:0] parent,
        input logic [NAME_W-1:0]   name,
        input logic [KIND_W-1:0]   kind
    );
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid          <= 1'b1;
        i_parent_present <= present;
        i_parent_slot    <= parent;
        i_name_id        <= name;
        i_kind_code      <= kind;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        expected_results.push_back(intern_lookup(present, parent, name, kind));
    endtask

    // Result side: the receiver stalls at random at the current rate.
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic note_mismatch(
        input string          what,
        input t_intern_result exp_r,
        input t_intern_result got_r
    );
        mismatch_count = mismatch_count + 1;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0d: %s: expected status %0d slot %0d size %0d,",
                     cycle_count, what, exp_r.status, exp_r.slot, exp_r.size,
                     " got status %0d slot %0d size %0d",
                     got_r.status, got_r.slot, got_r.size);
        end
    endtask

    // Every result transaction is matched against the oldest expectation.
    always @(posedge i_clk) begin
        t_intern_result got_r;
        t_intern_result exp_r;
        got_r = '{status: o_result_status, slot: o_slot_id, size: o_registry_size};
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                note_mismatch("result with no request pending", '0, got_r);
            end else begin
                exp_r = expected_results.pop_front();
                if (got_r !== exp_r) begin
                    note_mismatch("result mismatch", exp_r, got_r);
                end
            end
        end
    end

    // Watchdog: a hung block ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------

    // A well-formed triple under an existing parent. Half of the names are
    // drawn from a tiny range so that siblings share names and differ in kind
    // or parent, which piles entries into the same probe chains.
    task automatic send_new_triple();
        logic [NAME_W-1:0] name;
        name = ($urandom_range(1) == 0) ? NAME_W'($urandom) : NAME_W'($urandom_range(16, 1));
        if (name == '0) begin
            name = NAME_W'(1);
        end
        send_request(1'b1, PARENT_W'($urandom_range(stored_count, 0)), name,
                     KIND_W'($urandom_range(255, 1)));
    endtask

    // Ask again for an identity that is already stored.
    task automatic send_known_triple();
        int unsigned s;
        s = $urandom_range(stored_count, 1);
        send_request(1'b1, slot_parent[s], slot_name[s], slot_kind[s]);
    endtask

    // A malformed request with the other fields random.
    task automatic send_noise();
        t_noise_kind         flavor;
        logic [PARENT_W-1:0] parent;
        logic [NAME_W-1:0]   name;
        logic [KIND_W-1:0]   kind;
        flavor = t_noise_kind'($urandom_range(NOISE_UNKNOWN_PARENT, NOISE_NULL_PARENT));
        parent = PARENT_W'($urandom_range(stored_count, 0));
        name   = NAME_W'($urandom) | NAME_W'(1);
        kind   = KIND_W'($urandom_range(255, 1));
        case (flavor)
            NOISE_NULL_PARENT: begin
                send_request(1'b0, PARENT_W'($urandom), NAME_W'($urandom),
                             KIND_W'($urandom));
            end
            NOISE_ZERO_NAME: begin
                send_request(1'b1, parent, '0, kind);
            end
            NOISE_ZERO_KIND: begin
                send_request(1'b1, parent, name, '0);
            end
            default: begin
                // Parent slot beyond the highest slot assigned so far.
                send_request(1'b1, PARENT_W'($urandom_range(2**PARENT_W - 1, stored_count + 1)),
                             name, kind);
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Malformed requests on the empty table: each field that can make a request
    // invalid, alone and at its extremes.
    task automatic test_reject_malformed();
        send_request(1'b0, '0, NAME_W'(1), KIND_W'(1));
        send_request(1'b0, '0, '0, '0);
        send_request(1'b1, '0, '0, KIND_W'(1));
        send_request(1'b1, '0, NAME_W'(5), '0);
        send_request(1'b1, PARENT_W'(1), NAME_W'(5), KIND_W'(1));
        send_request(1'b1, '1, '1, '1);
    endtask

    // Inserts below the root and along a chain, lookups of existing triples, near
    // misses that differ from a stored triple in one field only, and a parent past the newest slot.
    task automatic test_insert_and_lookup();
        send_request(1'b1, '0, '1, '1);
        send_request(1'b1, '0, '1, '1);
        // The parent slot equal to the newest slot is the highest one allowed.
        send_request(1'b1, PARENT_W'(1), NAME_W'(1), KIND_W'(1));
        send_request(1'b1, PARENT_W'(2), NAME_W'(1), KIND_W'(1));
        send_request(1'b1, PARENT_W'(3), 32'h8000_0000, 8'h80);
        send_request(1'b1, PARENT_W'(5), NAME_W'(7), KIND_W'(3));
        send_request(1'b1, '0, '1, 8'hfe);
        send_request(1'b1, '0, 32'hffff_fffe, '1);
        send_request(1'b1, '0, NAME_W'(1), KIND_W'(1));
        send_request(1'b1, PARENT_W'(1), NAME_W'(1), KIND_W'(1));
        send_request(1'b1, PARENT_W'(4), 32'h5555_aaaa, 8'h55);
    endtask

    // Mostly new identities with random content, plus lookups of stored ones and
    // some malformed noise. About two thirds new triples fill the table well
    // within the random budget, so the later part runs against a full table.
    task automatic test_random_traffic(input int items, input int send_pct, input int recv_pct);
        int unsigned pick;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (items) begin
            pick = $urandom_range(99);
            if (pick < 65 || stored_count == 0) begin
                send_new_triple();
            end else if (pick < 85) begin
                send_known_triple();
            end else begin
                send_noise();
            end
        end
    endtask

    // Makes sure the table is full, then checks that new triples are refused,
    // stored ones are still found, and malformed ones are still rejected.
    task automatic test_full_table();
        while (stored_count < DEF_CAPACITY) begin
            send_new_triple();
        end
        send_request(1'b1, PARENT_W'(DEF_CAPACITY), NAME_W'(9), KIND_W'(9));
        send_request(1'b1, '0, 32'h1234_5678, 8'h42);
        send_request(1'b1, slot_parent[1], slot_name[1], slot_kind[1]);
        send_request(1'b1, slot_parent[DEF_CAPACITY], slot_name[DEF_CAPACITY],
                     slot_kind[DEF_CAPACITY]);
        send_request(1'b1, PARENT_W'(DEF_CAPACITY + 1), NAME_W'(9), KIND_W'(9));
        send_known_triple();
    endtask

    // Main sequence: reset, directed tests, random traffic in three idle phases,
    // the full-table test, then drain and verdict.
    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The block clears its bucket memory after reset with o_ready low; the
        // first request simply waits for the handshake.
        test_reject_malformed();
        test_insert_and_lookup();
        test_random_traffic(RANDOM_ITEMS / 3, 14, 83);
        test_random_traffic(RANDOM_ITEMS / 3, 83, 14);
        test_random_traffic(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3), 0, 0);
        test_full_table();

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
